@@ design/assert_macros.svh @@
// Assertion macros for the RTL, included by terrain_step_slope_mask.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ design/tssm_pkg.sv @@
// Types and constants for the terrain step/slope mask block.
`timescale 1ns / 1ps
`default_nettype none

package tssm_pkg;

  localparam int CFG_W       = 24;
  localparam int CFG_IDX_W   = 2;
  localparam int LIMIT_W     = 24;
  localparam int CNT_W       = 23;
  localparam int COL_OUT_W   = 10;
  localparam int ROW_OUT_W   = 12;
  localparam int OUT_BITS    = COL_OUT_W + ROW_OUT_W + 3 + 4 * CNT_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic [10:0]        RST_FRAME_WIDTH  = 11'd1024;
  localparam logic [12:0]        RST_FRAME_HEIGHT = 13'd1;
  localparam logic [LIMIT_W-1:0] RST_STEP_LIMIT   = 24'd250;
  localparam logic [LIMIT_W-1:0] RST_SLOPE_LIMIT  = 24'd182;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_STEP_LIMIT   = 2'd2,
    CFG_SLOPE_LIMIT  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic                 done;
    logic [CNT_W-1:0]     slope_tot;
    logic [CNT_W-1:0]     step_tot;
    logic [CNT_W-1:0]     trav_tot;
    logic [CNT_W-1:0]     obs_tot;
    logic                 slope;
    logic                 step;
    logic                 trav;
    logic [ROW_OUT_W-1:0] row;
    logic [COL_OUT_W-1:0] col;
  } res_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (c == CNT_MAX) ? c : c + 1'b1;
  endfunction

endpackage

`default_nettype wire

@@ design/tssm_ram.sv @@
// Generic single-write, single-read RAM with registered write-first read.
`timescale 1ns / 1ps
`default_nettype none

module tssm_ram #(
  parameter int WIDTH = 25,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_o <= wdata_i;
    end else begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ design/terrain_step_slope_mask.sv @@
// Streaming terrain traversability mask: step and slope limits over four neighbours.
//
// Input stream (s_axis): one transfer per item, raster order. tuser[0] = 0 is an
// elevation sample, 1 is a flush tick. Output stream (m_axis): one result per cell,
// tlast marks the last cell of the frame. Config: cfg_we_i writes cfg_wdata_i to
// register cfg_idx_i (width, height, step limit, slope rise limit);
// a width or height write restarts the frame.
// A cell is reported by the sample transfer directly below it; the last row is
// reported by one flush transfer per column once every row has arrived. Samples
// of row 0 and ignored items produce no result.
// The result is registered in the output register by the transfer that causes it.
// Throughput: one item per cycle while no result waits on m_axis_tready; set by
// the single output register and the registered reads of the three row RAMs (two
// middle-row copies, one upper-row), which prefetch the next column every cycle.
// Reset: positions and counts clear, config registers take their reset values; the
// row RAMs hold no defined data and row 0 of each frame fills them before use.
// Stall: while a result waits with m_axis_tready low, s_axis_tready is low and
// the result holds; a waiting result is taken in the same cycle as a new item.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module terrain_step_slope_mask
  import tssm_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096,
  parameter int ELEV_BITS  = 24
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // config write port
  input  logic                               cfg_we_i,
  input  logic [CFG_IDX_W-1:0]               cfg_idx_i,
  input  logic [CFG_W-1:0]                   cfg_wdata_i,
  // input stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata: elevation_mm [ELEV_BITS-1:0], sample_known [ELEV_BITS], zero pad
  input  logic [((ELEV_BITS+8)/8)*8-1:0]     s_axis_tdata,
  // tuser: req_type [0]
  input  logic [0:0]                         s_axis_tuser,
  // output stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tdata: cell_column [9:0], cell_row [21:10], cell_traversable [22],
  //   cell_step_blocked [23], cell_slope_blocked [24], observed_total [47:25],
  //   traversable_total [70:48], step_blocked_total [93:71],
  //   slope_blocked_total [116:94], zero pad
  output logic [OUT_TDATA_W-1:0]             m_axis_tdata,
  // frame_done
  output logic                               m_axis_tlast
);

  localparam int ENT_W  = ELEV_BITS + 1;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int COLW_W = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W  = $clog2(MAX_HEIGHT + 1);
  localparam int CMP_W  = (ENT_W > LIMIT_W) ? ENT_W : LIMIT_W;
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAX_WIDTH - 1);

  // config registers
  logic [10:0]        cfg_width_q;
  logic [12:0]        cfg_height_q;
  logic [LIMIT_W-1:0] step_lim_q, slope_lim_q;
  logic               restart_cfg;

  assign restart_cfg = cfg_we_i &&
                       ((cfg_idx_i == CFG_FRAME_WIDTH) || (cfg_idx_i == CFG_FRAME_HEIGHT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= RST_FRAME_WIDTH;
      cfg_height_q <= RST_FRAME_HEIGHT;
      step_lim_q   <= RST_STEP_LIMIT;
      slope_lim_q  <= RST_SLOPE_LIMIT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FRAME_WIDTH:  cfg_width_q  <= cfg_wdata_i[10:0];
        CFG_FRAME_HEIGHT: cfg_height_q <= cfg_wdata_i[12:0];
        CFG_STEP_LIMIT:   step_lim_q   <= cfg_wdata_i[LIMIT_W-1:0];
        CFG_SLOPE_LIMIT:  slope_lim_q  <= cfg_wdata_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped frame size
  logic [COLW_W-1:0] w_use;
  logic [ROW_W-1:0]  h_use;

  always_comb begin
    if (cfg_width_q == '0) begin
      w_use = COLW_W'(1);
    end else if (32'(cfg_width_q) > 32'(MAX_WIDTH)) begin
      w_use = COLW_W'(MAX_WIDTH);
    end else begin
      w_use = COLW_W'(cfg_width_q);
    end
    if (cfg_height_q == '0) begin
      h_use = ROW_W'(1);
    end else if (32'(cfg_height_q) > 32'(MAX_HEIGHT)) begin
      h_use = ROW_W'(MAX_HEIGHT);
    end else begin
      h_use = ROW_W'(cfg_height_q);
    end
  end

  // frame state
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [CNT_W-1:0] obs_q, obs_d, trav_q, trav_d, step_q, step_d, slope_q, slope_d;
  logic [ENT_W-1:0] held_q, held_d;
  logic             out_valid_q, out_valid_d;
  res_t             res_q, res_d;

  // row RAM read data, valid for col_q (mid_b: the column after col_q)
  logic [ENT_W-1:0] mid_a_rdata, mid_b_rdata, up_rdata;
  logic [COL_W-1:0] rd_addr, rd_addr_nxt;

  // item decode
  logic             s_fire, is_flush, known_in;
  logic [ENT_W-1:0] entry;
  logic             last_col, rows_done, sample_take, sample_emit, flush_emit, emit;
  logic             restart;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign is_flush      = s_axis_tuser[0];
  assign known_in      = s_axis_tdata[ELEV_BITS];
  assign entry         = known_in ? {1'b1, s_axis_tdata[ELEV_BITS-1:0]} : '0;

  assign last_col    = (COLW_W'(col_q) + COLW_W'(1)) >= w_use;
  assign rows_done   = row_q >= h_use;
  assign sample_take = !is_flush && !rows_done;
  assign sample_emit = sample_take && (row_q != '0);
  assign flush_emit  = is_flush && rows_done;
  assign emit        = sample_emit || flush_emit;
  assign restart     = restart_cfg || (s_fire && flush_emit && last_col);

  // judge the cell at col_q
  logic [ENT_W-1:0] centre;
  logic             any_nb, step_hit, slope_hit, trav_hit;

  assign centre = mid_a_rdata;

  always_comb begin
    logic [ENT_W-1:0]        nb  [4];
    logic                    has [4];
    logic signed [ENT_W-1:0] diff;
    logic [ENT_W-1:0]        rise;
    nb[0]  = held_q;
    nb[1]  = mid_b_rdata;
    nb[2]  = up_rdata;
    nb[3]  = entry;
    has[0] = col_q != '0;
    has[1] = !last_col;
    has[2] = row_q >= ROW_W'(2);
    has[3] = !is_flush;
    any_nb    = 1'b0;
    step_hit  = 1'b0;
    slope_hit = 1'b0;
    for (int k = 0; k < 4; k++) begin
      diff = $signed({centre[ELEV_BITS-1], centre[ELEV_BITS-1:0]}) -
             $signed({nb[k][ELEV_BITS-1], nb[k][ELEV_BITS-1:0]});
      rise = diff[ENT_W-1] ? ENT_W'(-diff) : ENT_W'(diff);
      if (centre[ELEV_BITS] && has[k] && nb[k][ELEV_BITS]) begin
        any_nb = 1'b1;
        if (CMP_W'(rise) > CMP_W'(step_lim_q)) begin
          step_hit = 1'b1;
        end
        if (CMP_W'(rise) > CMP_W'(slope_lim_q)) begin
          slope_hit = 1'b1;
        end
      end
    end
    trav_hit = any_nb && !step_hit && !slope_hit;
  end

  // next state
  always_comb begin
    col_d       = col_q;
    row_d       = row_q;
    obs_d       = obs_q;
    trav_d      = trav_q;
    step_d      = step_q;
    slope_d     = slope_q;
    held_d      = held_q;
    out_valid_d = out_valid_q;
    res_d       = res_q;

    if (s_fire && emit && centre[ELEV_BITS]) begin
      obs_d = sat_inc(obs_q);
      if (trav_hit) begin
        trav_d = sat_inc(trav_q);
      end
      if (step_hit) begin
        step_d = sat_inc(step_q);
      end
      if (slope_hit) begin
        slope_d = sat_inc(slope_q);
      end
    end

    if (s_axis_tready) begin
      out_valid_d = s_fire && emit;
    end
    if (s_fire && emit) begin
      res_d.col       = COL_OUT_W'(col_q);
      res_d.row       = ROW_OUT_W'(row_q - ROW_W'(1));
      res_d.trav      = trav_hit;
      res_d.step      = step_hit;
      res_d.slope     = slope_hit;
      res_d.obs_tot   = obs_d;
      res_d.trav_tot  = trav_d;
      res_d.step_tot  = step_d;
      res_d.slope_tot = slope_d;
      res_d.done      = flush_emit && last_col;
      held_d          = centre;
    end

    if (s_fire && (sample_take || flush_emit)) begin
      col_d = last_col ? '0 : col_q + 1'b1;
      if (sample_take && last_col) begin
        row_d = row_q + 1'b1;
      end
    end

    if (restart) begin
      col_d   = '0;
      row_d   = '0;
      obs_d   = '0;
      trav_d  = '0;
      step_d  = '0;
      slope_d = '0;
      held_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      obs_q       <= '0;
      trav_q      <= '0;
      step_q      <= '0;
      slope_q     <= '0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      col_q       <= col_d;
      row_q       <= row_d;
      obs_q       <= obs_d;
      trav_q      <= trav_d;
      step_q      <= step_d;
      slope_q     <= slope_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  // row RAMs: prefetch the next column and the one after it
  assign rd_addr     = col_d;
  assign rd_addr_nxt = (col_d == COL_LAST) ? '0 : col_d + 1'b1;

  tssm_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_WIDTH)
  ) u_mid_a (
    .clk_i   (clk_i),
    .we_i    (s_fire && sample_take),
    .waddr_i (col_q),
    .wdata_i (entry),
    .raddr_i (rd_addr),
    .rdata_o (mid_a_rdata)
  );

  tssm_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_WIDTH)
  ) u_mid_b (
    .clk_i   (clk_i),
    .we_i    (s_fire && sample_take),
    .waddr_i (col_q),
    .wdata_i (entry),
    .raddr_i (rd_addr_nxt),
    .rdata_o (mid_b_rdata)
  );

  tssm_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_WIDTH)
  ) u_upper (
    .clk_i   (clk_i),
    .we_i    (s_fire && sample_emit),
    .waddr_i (col_q),
    .wdata_i (centre),
    .raddr_i (rd_addr),
    .rdata_o (up_rdata)
  );

  // output stream
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = res_q.done;
  assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_BITS){1'b0}},
                          res_q.slope_tot, res_q.step_tot, res_q.trav_tot, res_q.obs_tot,
                          res_q.slope, res_q.step, res_q.trav, res_q.row, res_q.col};

  // checks
  `ASSERT_IMPL(a_col_in_frame, 1'b1, COLW_W'(col_q) < w_use)
  `ASSERT_NEXT(a_frame_restart, s_fire && flush_emit && last_col,
               col_q == '0 && row_q == '0 && obs_q == '0)
  `ASSERT_IMPL(a_trav_clean, out_valid_q && res_q.trav,
               !res_q.step && !res_q.slope && res_q.obs_tot != '0)

endmodule

`default_nettype wire
